FILE: rtl/yin_pitch_period_estimator_assert.svh
// assertion macros for the yin pitch period estimator
// expects i_clk and i_rst_n in the scope of use; empty when SYNTH is defined
`ifndef YIN_PITCH_PERIOD_ESTIMATOR_ASSERT_SVH
`define YIN_PITCH_PERIOD_ESTIMATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define YPE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ype assertion failed");
// next-cycle implication
`define YPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ype assertion failed");
`else
`define YPE_ASSERT_IMPL(lbl, ante, cons)
`define YPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/ype_pkg.sv
// shared sizes, register codes and reset values for the yin pitch estimator
// no dependencies
package ype_pkg;

    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned MAX_FRAME   = 4096;
    localparam int unsigned MAX_LAG     = 1024;

    localparam int unsigned FA_W      = $clog2(MAX_FRAME);
    localparam int unsigned CNT_W     = FA_W + 1;
    localparam int unsigned LAG_W     = $clog2(MAX_LAG) + 1;
    localparam int unsigned D_W       = FA_W + 2 * SAMPLE_BITS;
    localparam int unsigned PROD_W    = D_W + LAG_W - 1;
    localparam int unsigned DIV_N_W   = 32;
    localparam int unsigned DCNT_W    = $clog2(DIV_N_W) + 1;
    localparam int unsigned NORM_W    = 20;
    localparam int unsigned PERIOD_W  = 18;
    localparam int unsigned PITCH_W   = 22;
    localparam int unsigned RATE_W    = 18;
    localparam int unsigned Q16_W     = 16;
    localparam int unsigned CFG_W     = 18;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [NORM_W-1:0]   NORM_SAT   = '1;
    localparam logic [NORM_W-1:0]   NORM_ONE   = NORM_W'(65536);
    localparam logic [PERIOD_W-1:0] PERIOD_SAT = '1;
    localparam logic [PITCH_W-1:0]  PITCH_SAT  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LAG   = 3'd0,
        CFG_MAX_LAG   = 3'd1,
        CFG_FRAME_LEN = 3'd2,
        CFG_RATE      = 3'd3,
        CFG_ABS_THR   = 3'd4,
        CFG_VOICED    = 3'd5
    } t_cfg_idx;

    localparam logic [LAG_W-1:0]   RST_MIN_LAG   = LAG_W'(20);
    localparam logic [LAG_W-1:0]   RST_MAX_LAG   = LAG_W'(686);
    localparam logic [CNT_W-1:0]   RST_FRAME_LEN = CNT_W'(2208);
    localparam logic [RATE_W-1:0]  RST_RATE      = RATE_W'(48000);
    localparam logic [Q16_W-1:0]   RST_ABS_THR   = Q16_W'(7864);
    localparam logic [Q16_W-1:0]   RST_VOICED    = Q16_W'(13107);

endpackage

FILE: rtl/ype_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module ype_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/yin_pitch_period_estimator.sv
// yin pitch period estimator top level: frame capture, difference sums,
// normalisation, dip search, refinement and pitch; uses ype_pkg, ype_ram
//
//  channel  direction  handshake                     payload
//  in       to block   i_in_valid / o_in_stall       i_sample
//  out      from block o_out_valid / i_out_stall     o_voiced o_best_lag o_period_q8
//                                                    o_dip_value o_pitch_q4
//  cfg      to block   i_cfg_we                      i_cfg_idx i_cfg_data
//
// samples are taken one per cycle until the frame is full; the frame is then
// processed by the single multiply-accumulate unit (one product per cycle from
// two frame store read ports) and the shared 1-bit-per-cycle divider
// reset is synchronous and active low; it clears the sample count and control and loads the configuration reset values
// the next frame loads while a result waits on a stalled output beat
`include "yin_pitch_period_estimator_assert.svh"
module yin_pitch_period_estimator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [ype_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_voiced,
    output logic [ype_pkg::LAG_W-1:0]              o_best_lag,
    output logic [ype_pkg::PERIOD_W-1:0]           o_period_q8,
    output logic [ype_pkg::NORM_W-1:0]             o_dip_value,
    output logic [ype_pkg::PITCH_W-1:0]            o_pitch_q4,
    input  logic                                   i_cfg_we,
    input  logic [ype_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [ype_pkg::CFG_W-1:0]              i_cfg_data
);
    import ype_pkg::*;

    localparam int unsigned PER_W = DIV_N_W + 1;

    typedef enum logic [3:0] {
        S_LOAD, S_SETUP, S_MAC, S_MUL, S_NCHK, S_DIV, S_SEL, S_FIN, S_PER, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_NORM, DIV_OFS, DIV_PITCH
    } t_div_op;

    typedef enum logic [1:0] {
        DIP_SEARCH, DIP_DESC, DIP_DONE
    } t_dip;

    // configuration registers
    logic [LAG_W-1:0]  r_min_lag, r_max_lag;
    logic [CNT_W-1:0]  r_frame_len;
    logic [RATE_W-1:0] r_sample_rate;
    logic [Q16_W-1:0]  r_abs_thr, r_voiced_lim;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;

    // difference-sum unit
    logic [FA_W-1:0]          r_i;
    logic [CNT_W-1:0]         r_w;
    logic [LAG_W-1:0]         r_tau;
    logic                     r_issue, r_rd_v, r_sq_v;
    logic [2*SAMPLE_BITS:0]   r_sq;
    logic [D_W-1:0]           r_acc;
    logic [PROD_W-1:0]        r_prod, r_run;

    // shared divider
    t_div_op              r_div_op;
    logic [PROD_W-1:0]    r_rem, r_dsr;
    logic [DIV_N_W-1:0]   r_nbits, r_quo;
    logic [DCNT_W-1:0]    r_dcnt;
    logic                 r_ofs_neg;

    // dip search, done on the fly as normalised values arrive
    logic [NORM_W-1:0] r_norm, r_prev;
    logic [NORM_W-1:0] r_g_mv, r_g_a, r_g_c;
    logic [LAG_W-1:0]  r_g_best;
    logic              r_g_need_c;
    t_dip              r_dip_st;
    logic [LAG_W-1:0]  r_dip_best;
    logic [NORM_W-1:0] r_dip_a, r_dip_b, r_dip_c;

    // frame result
    logic                   r_res_voiced;
    logic [LAG_W-1:0]       r_res_best;
    logic [NORM_W-1:0]      r_res_dip;
    logic [PERIOD_W-1:0]    r_res_per;
    logic [PITCH_W-1:0]     r_res_pitch;
    logic signed [PER_W-1:0] r_period;

    // output register
    logic                   r_out_valid, r_out_voiced;
    logic [LAG_W-1:0]       r_out_best;
    logic [PERIOD_W-1:0]    r_out_per;
    logic [NORM_W-1:0]      r_out_dip;
    logic [PITCH_W-1:0]     r_out_pitch;

    // clamped configuration
    logic [CNT_W-1:0] c_len;
    logic [LAG_W-1:0] c_lo, c_hi0, c_hi;

    always_comb begin
        if (r_frame_len == '0) begin
            c_len = CNT_W'(1);
        end else if (r_frame_len > CNT_W'(MAX_FRAME)) begin
            c_len = CNT_W'(MAX_FRAME);
        end else begin
            c_len = r_frame_len;
        end
        if (r_min_lag < LAG_W'(2)) begin
            c_lo = LAG_W'(2);
        end else if (r_min_lag > LAG_W'(MAX_LAG)) begin
            c_lo = LAG_W'(MAX_LAG);
        end else begin
            c_lo = r_min_lag;
        end
        if (r_max_lag < LAG_W'(2)) begin
            c_hi0 = LAG_W'(2);
        end else if (r_max_lag > LAG_W'(MAX_LAG)) begin
            c_hi0 = LAG_W'(MAX_LAG);
        end else begin
            c_hi0 = r_max_lag;
        end
        c_hi = (c_hi0 < c_lo) ? c_lo : c_hi0;
    end

    // frame store, two copies so both taps are read each cycle
    logic                   w_accept, w_we;
    logic [CNT_W-1:0]       c_addr_sum, c_count_inc;
    logic [SAMPLE_BITS-1:0] w_xa, w_xb;

    assign o_in_stall  = (r_state != S_LOAD);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_we        = w_accept && (r_count < CNT_W'(MAX_FRAME));
    assign c_addr_sum  = CNT_W'(r_i) + CNT_W'(r_tau);
    assign c_count_inc = r_count + CNT_W'(1);

    ype_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAME)) u_frame_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[FA_W-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_i),
        .o_rdata (w_xa)
    );

    ype_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAME)) u_frame_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[FA_W-1:0]),
        .i_wdata (i_sample),
        .i_raddr (c_addr_sum[FA_W-1:0]),
        .o_rdata (w_xb)
    );

    // squared difference of the two taps
    logic signed [SAMPLE_BITS:0]     c_df;
    logic signed [2*SAMPLE_BITS+1:0] c_sq_full;
    logic [LAG_W-1:0]                c_cnt;
    logic [D_W+LAG_W-1:0]            c_prod_full;

    assign c_df        = $signed({w_xa[SAMPLE_BITS-1], w_xa})
                       - $signed({w_xb[SAMPLE_BITS-1], w_xb});
    assign c_sq_full   = c_df * c_df;
    assign c_cnt       = r_tau - c_lo + LAG_W'(1);
    assign c_prod_full = r_acc * c_cnt;

    // divider step
    logic [PROD_W:0]    c_trial, c_sub;
    logic               c_ge;
    logic [DIV_N_W-1:0] c_quo_next;

    assign c_trial    = {r_rem, r_nbits[DIV_N_W-1]};
    assign c_ge       = (c_trial >= {1'b0, r_dsr});
    assign c_sub      = c_trial - {1'b0, r_dsr};
    assign c_quo_next = {r_quo[DIV_N_W-2:0], c_ge};

    // pick the lag and its neighbours
    logic [LAG_W-1:0]          c_best;
    logic [NORM_W-1:0]         c_a, c_b, c_c;
    logic signed [NORM_W+2:0]  c_den;
    logic signed [NORM_W:0]    c_amc;
    logic signed [NORM_W+7:0]  c_num;
    logic [NORM_W+7:0]         c_num_mag;
    logic [NORM_W+2:0]         c_den_mag;
    logic                      c_voiced, c_refine;

    always_comb begin
        if (r_dip_st == DIP_DONE) begin
            c_best = r_dip_best;
            c_a    = r_dip_a;
            c_b    = r_dip_b;
            c_c    = r_dip_c;
        end else begin
            c_best = r_g_best;
            c_a    = r_g_a;
            c_b    = r_g_mv;
            c_c    = r_g_c;
        end
        c_den     = $signed({3'b000, c_a}) + $signed({3'b000, c_c})
                  - $signed({2'b00, c_b, 1'b0});
        c_amc     = $signed({1'b0, c_a}) - $signed({1'b0, c_c});
        c_num     = $signed({c_amc, 7'b0});
        c_num_mag = c_num[NORM_W+7] ? (NORM_W+8)'(-c_num) : c_num;
        c_den_mag = c_den[NORM_W+2] ? (NORM_W+3)'(-c_den) : c_den;
        c_voiced  = (c_b <= NORM_W'(r_voiced_lim));
        c_refine  = c_voiced && (c_best > c_lo) && (c_best < c_hi) && (c_den != '0);
    end

    // period saturation
    logic [PERIOD_W-1:0] c_per_sat;
    logic                c_per_pos;

    always_comb begin
        c_per_pos = (r_period > $signed(PER_W'(0)));
        if (!c_per_pos) begin
            c_per_sat = '0;
        end else if (r_period > $signed(PER_W'(PERIOD_SAT))) begin
            c_per_sat = PERIOD_SAT;
        end else begin
            c_per_sat = r_period[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_count       <= '0;
            r_issue       <= 1'b0;
            r_rd_v        <= 1'b0;
            r_sq_v        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_min_lag     <= RST_MIN_LAG;
            r_max_lag     <= RST_MAX_LAG;
            r_frame_len   <= RST_FRAME_LEN;
            r_sample_rate <= RST_RATE;
            r_abs_thr     <= RST_ABS_THR;
            r_voiced_lim  <= RST_VOICED;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_LAG:   r_min_lag     <= i_cfg_data[LAG_W-1:0];
                    CFG_MAX_LAG:   r_max_lag     <= i_cfg_data[LAG_W-1:0];
                    CFG_FRAME_LEN: r_frame_len   <= i_cfg_data[CNT_W-1:0];
                    CFG_RATE:      r_sample_rate <= i_cfg_data[RATE_W-1:0];
                    CFG_ABS_THR:   r_abs_thr     <= i_cfg_data[Q16_W-1:0];
                    CFG_VOICED:    r_voiced_lim  <= i_cfg_data[Q16_W-1:0];
                    default: ;
                endcase
            end

            // a beat taken while a new result is loaded keeps valid high
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            // multiply-accumulate pipeline: read, square, accumulate
            r_rd_v <= r_issue;
            r_sq_v <= r_rd_v;
            r_sq   <= c_sq_full[2*SAMPLE_BITS:0];
            if (r_sq_v) begin
                r_acc <= r_acc + D_W'(r_sq);
            end

            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (c_count_inc >= c_len) begin
                            r_count <= '0;
                            r_state <= S_SETUP;
                        end else begin
                            r_count <= c_count_inc;
                        end
                    end
                end
                S_SETUP: begin
                    if (c_len <= CNT_W'(c_hi)) begin
                        // empty window
                        r_res_voiced <= 1'b0;
                        r_res_best   <= '0;
                        r_res_per    <= '0;
                        r_res_dip    <= '0;
                        r_res_pitch  <= '0;
                        r_state      <= S_OUT;
                    end else begin
                        r_w      <= c_len - CNT_W'(c_hi);
                        r_tau    <= c_lo;
                        r_run    <= '0;
                        r_acc    <= '0;
                        r_i      <= '0;
                        r_issue  <= 1'b1;
                        r_dip_st <= DIP_SEARCH;
                        r_state  <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_issue) begin
                        r_i <= r_i + FA_W'(1);
                        if (CNT_W'(r_i) == r_w - CNT_W'(1)) begin
                            r_issue <= 1'b0;
                        end
                    end else if (!r_rd_v && !r_sq_v) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= c_prod_full[PROD_W-1:0];
                    r_run   <= r_run + PROD_W'(r_acc);
                    r_state <= S_NCHK;
                end
                S_NCHK: begin
                    if (r_run == '0) begin
                        r_norm  <= NORM_ONE;
                        r_state <= S_SEL;
                    end else if ((PROD_W+4)'(r_prod) >= {r_run, 4'b0000}) begin
                        r_norm  <= NORM_SAT;
                        r_state <= S_SEL;
                    end else begin
                        // quotient below 2^20: start with the top bits in place
                        r_rem    <= PROD_W'(r_prod[PROD_W-1:4]);
                        r_nbits  <= {r_prod[3:0], (DIV_N_W-4)'(0)};
                        r_dsr    <= r_run;
                        r_quo    <= '0;
                        r_dcnt   <= DCNT_W'(NORM_W);
                        r_div_op <= DIV_NORM;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= c_ge ? c_sub[PROD_W-1:0] : c_trial[PROD_W-1:0];
                    r_nbits <= {r_nbits[DIV_N_W-2:0], 1'b0};
                    r_quo   <= c_quo_next;
                    r_dcnt  <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(1)) begin
                        unique case (r_div_op)
                            DIV_NORM: begin
                                r_norm  <= (c_quo_next[DIV_N_W-1:NORM_W] != '0)
                                         ? NORM_SAT : c_quo_next[NORM_W-1:0];
                                r_state <= S_SEL;
                            end
                            DIV_OFS: begin
                                if (r_ofs_neg) begin
                                    r_period <= r_period - $signed({1'b0, c_quo_next});
                                end else begin
                                    r_period <= r_period + $signed({1'b0, c_quo_next});
                                end
                                r_state <= S_PER;
                            end
                            DIV_PITCH: begin
                                r_res_pitch <= (c_quo_next > DIV_N_W'(PITCH_SAT))
                                             ? PITCH_SAT : c_quo_next[PITCH_W-1:0];
                                r_state     <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_SEL: begin
                    // global minimum with its neighbours
                    if (r_tau == c_lo) begin
                        r_g_mv     <= r_norm;
                        r_g_best   <= r_tau;
                        r_g_need_c <= 1'b1;
                    end else if (r_norm < r_g_mv) begin
                        r_g_mv     <= r_norm;
                        r_g_best   <= r_tau;
                        r_g_a      <= r_prev;
                        r_g_need_c <= 1'b1;
                    end else if (r_g_need_c) begin
                        r_g_c      <= r_norm;
                        r_g_need_c <= 1'b0;
                    end
                    // first dip under the threshold, then down to its floor
                    case (r_dip_st)
                        DIP_SEARCH: begin
                            if ((r_tau > c_lo) && (r_tau < c_hi)
                                    && (r_norm < NORM_W'(r_abs_thr))) begin
                                r_dip_st   <= DIP_DESC;
                                r_dip_best <= r_tau;
                                r_dip_b    <= r_norm;
                                r_dip_a    <= r_prev;
                            end
                        end
                        DIP_DESC: begin
                            if ((r_tau < c_hi) && (r_norm < r_dip_b)) begin
                                r_dip_best <= r_tau;
                                r_dip_b    <= r_norm;
                                r_dip_a    <= r_prev;
                            end else begin
                                r_dip_c  <= r_norm;
                                r_dip_st <= DIP_DONE;
                            end
                        end
                        default: ;
                    endcase
                    r_prev <= r_norm;
                    if (r_tau == c_hi) begin
                        r_state <= S_FIN;
                    end else begin
                        r_tau   <= r_tau + LAG_W'(1);
                        r_acc   <= '0;
                        r_i     <= '0;
                        r_issue <= 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_FIN: begin
                    r_res_best   <= c_best;
                    r_res_dip    <= c_b;
                    r_res_voiced <= c_voiced;
                    r_period     <= $signed(PER_W'({c_best, 8'h00}));
                    if (c_refine) begin
                        r_rem     <= '0;
                        r_nbits   <= DIV_N_W'({c_num_mag, 1'b0}) + DIV_N_W'(c_den_mag);
                        r_dsr     <= PROD_W'({c_den_mag, 1'b0});
                        r_quo     <= '0;
                        r_dcnt    <= DCNT_W'(DIV_N_W);
                        r_ofs_neg <= c_num[NORM_W+7] ^ c_den[NORM_W+2];
                        r_div_op  <= DIV_OFS;
                        r_state   <= S_DIV;
                    end else begin
                        r_state <= S_PER;
                    end
                end
                S_PER: begin
                    r_res_per <= c_per_sat;
                    if (r_res_voiced && c_per_pos) begin
                        r_rem    <= '0;
                        r_nbits  <= DIV_N_W'({r_sample_rate, 13'h0000})
                                  + DIV_N_W'(c_per_sat);
                        r_dsr    <= PROD_W'({c_per_sat, 1'b0});
                        r_quo    <= '0;
                        r_dcnt   <= DCNT_W'(DIV_N_W);
                        r_div_op <= DIV_PITCH;
                        r_state  <= S_DIV;
                    end else begin
                        r_res_voiced <= 1'b0;
                        r_res_pitch  <= '0;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_voiced <= r_res_voiced;
                        r_out_best   <= r_res_best;
                        r_out_per    <= r_res_per;
                        r_out_dip    <= r_res_dip;
                        r_out_pitch  <= r_res_pitch;
                        r_state      <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_voiced    = r_out_voiced;
    assign o_best_lag  = r_out_best;
    assign o_period_q8 = r_out_per;
    assign o_dip_value = r_out_dip;
    assign o_pitch_q4  = r_out_pitch;

    // far tap stays inside the loaded frame
    `YPE_ASSERT_IMPL(a_tap_in_frame, (r_state == S_MAC) && r_issue, c_addr_sum < c_len)
    // divider never sits with an exhausted count
    `YPE_ASSERT_IMPL(a_div_count, r_state == S_DIV, r_dcnt != '0)
    // a voiced beat always carries a period
    `YPE_ASSERT_IMPL(a_voiced_period, r_out_valid && r_out_voiced, r_out_per != '0)
    // an inner lag is always followed by its next difference sum
    `YPE_ASSERT_NEXT(a_next_lag, (r_state == S_SEL) && (r_tau != c_hi), r_state == S_MAC)

endmodule

FILE: tb/tb_yin_pitch_period_estimator.sv
// testbench for the yin pitch period estimator: directed table then random frames,
// every result checked against an in-bench frame predictor or a typed all-zero result; uses ype_pkg
module tb_yin_pitch_period_estimator;
    import ype_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct packed {
        logic                voiced;
        logic [LAG_W-1:0]    best_lag;
        logic [PERIOD_W-1:0] period_q8;
        logic [NORM_W-1:0]   dip_value;
        logic [PITCH_W-1:0]  pitch_q4;
    } t_pitch_result;

    // one row of the directed table: a register write or a sample beat
    typedef struct {
        bit                      is_cfg;
        t_cfg_idx                idx;
        logic [CFG_W-1:0]        data;
        logic signed [15:0]      smp;
        bit                      zero_result;  // row closes a frame with an all-zero result
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_voiced;
    logic [LAG_W-1:0]              o_best_lag;
    logic [PERIOD_W-1:0]           o_period_q8;
    logic [NORM_W-1:0]             o_dip_value;
    logic [PITCH_W-1:0]            o_pitch_q4;
    logic                          i_cfg_we;
    logic [CFG_IDX_W-1:0]          i_cfg_idx;
    logic [CFG_W-1:0]              i_cfg_data;

    yin_pitch_period_estimator dut (.*);

    always #5 i_clk = ~i_clk;

    // register mirror
    logic [10:0] m_min_lag, m_max_lag;
    logic [12:0] m_frame_len;
    logic [17:0] m_rate;
    logic [15:0] m_abs_thr, m_voiced_lim;

    // frame predictor state
    logic signed [15:0] frame_mem [MAX_FRAME];
    longint unsigned    diff_sum  [MAX_LAG+1];
    int unsigned        norm_q16  [MAX_LAG+1];
    int unsigned        fill_count;

    t_pitch_result pending_results[$];
    int            fail_count;
    int            cycle_count;
    int            sent_items;

    // ---------------------------------------------------------------- predictor
    function automatic int unsigned lag_lo();
        return (m_min_lag < 2) ? 2 : (m_min_lag > MAX_LAG) ? MAX_LAG : m_min_lag;
    endfunction

    function automatic int unsigned lag_hi();
        int unsigned h;
        h = (m_max_lag < 2) ? 2 : (m_max_lag > MAX_LAG) ? MAX_LAG : m_max_lag;
        return (h < lag_lo()) ? lag_lo() : h;
    endfunction

    function automatic int unsigned frame_len_eff();
        return (m_frame_len < 1) ? 1 : (m_frame_len > MAX_FRAME) ? MAX_FRAME : m_frame_len;
    endfunction

    // floor(d*cnt*65536/run), saturated to 20 bits, done by long division
    function automatic int unsigned norm_ratio(longint unsigned d, longint unsigned cnt,
                                               longint unsigned run);
        longint unsigned prod, q, r;
        prod = d * cnt;
        if (prod >= run * 16) return NORM_SAT;
        q = prod / run;
        r = prod % run;
        for (int k = 0; k < 16; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= run) begin
                r = r - run;
                q = q | 1;
            end
        end
        return (q > NORM_SAT) ? NORM_SAT : int'(q);
    endfunction

    function automatic longint rounded_quot(longint num, longint den);
        longint unsigned n, d, q;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (2 * n + d) / (2 * d);
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_pitch_result estimate_frame(int unsigned len);
        t_pitch_result   r;
        int unsigned     lo, hi, w, best, tau, mv;
        longint unsigned acc, mag, run, p, pitch;
        longint          period, a, b, c, den, df;
        bit              found, voiced;
        r      = '0;
        lo     = lag_lo();
        hi     = lag_hi();
        found  = 0;
        voiced = 1;
        pitch  = 0;
        if (len <= hi) return r;   // empty window
        w = len - hi;
        for (tau = lo; tau <= hi; tau++) begin
            acc = 0;
            for (int unsigned i = 0; i < w; i++) begin
                df  = longint'(frame_mem[i]) - longint'(frame_mem[i+tau]);
                mag = (df < 0) ? -df : df;
                acc += mag * mag;
            end
            diff_sum[tau] = acc;
        end
        run = 0;
        for (tau = lo; tau <= hi; tau++) begin
            run += diff_sum[tau];
            norm_q16[tau] = (run == 0) ? 65536 : norm_ratio(diff_sum[tau], tau - lo + 1, run);
        end
        // first dip under the threshold, walked down to its floor
        best = lo;
        for (tau = lo + 1; tau < hi; tau++) begin
            if (norm_q16[tau] < m_abs_thr) begin
                while (tau + 1 < hi && norm_q16[tau+1] < norm_q16[tau]) tau++;
                best  = tau;
                found = 1;
                break;
            end
        end
        if (!found) begin
            mv   = norm_q16[lo];
            best = lo;
            for (tau = lo + 1; tau <= hi; tau++)
                if (norm_q16[tau] < mv) begin
                    mv   = norm_q16[tau];
                    best = tau;
                end
        end
        period = longint'(best) * 256;
        if (norm_q16[best] > m_voiced_lim) begin
            voiced = 0;
        end else if (best > lo && best < hi) begin
            a   = norm_q16[best-1];
            b   = norm_q16[best];
            c   = norm_q16[best+1];
            den = a - 2 * b + c;
            if (den != 0) period += rounded_quot(128 * (a - c), den);
        end
        if (period <= 0) begin
            voiced = 0;
            period = 0;
        end
        if (period > PERIOD_SAT) period = PERIOD_SAT;
        if (voiced && period > 0) begin
            p     = period;
            pitch = (longint'(m_rate) * 8192 + p) / (2 * p);
            if (pitch > PITCH_SAT) pitch = PITCH_SAT;
        end
        r.voiced    = voiced;
        r.best_lag  = best[LAG_W-1:0];
        r.period_q8 = period[PERIOD_W-1:0];
        r.dip_value = norm_q16[best][NORM_W-1:0];
        r.pitch_q4  = voiced ? pitch[PITCH_W-1:0] : '0;
        return r;
    endfunction

    // returns 1 when this sample closes a frame
    function automatic bit take_sample(logic signed [15:0] s, output t_pitch_result r);
        int unsigned len;
        len = frame_len_eff();
        r   = '0;
        if (fill_count < MAX_FRAME) frame_mem[fill_count] = s;
        fill_count++;
        if (fill_count < len) return 0;
        fill_count = 0;
        r = estimate_frame(len);
        return 1;
    endfunction

    function automatic int frame_cycles();
        int w;
        w = int'(frame_len_eff()) - int'(lag_hi());
        if (w < 0) w = 0;
        return (lag_hi() - lag_lo() + 1) * (w + 30) + 100;
    endfunction

    // ---------------------------------------------------------------- drivers
    // write enable stays high; the caller drops it after the last write
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_LAG:   m_min_lag    = val[10:0];
            CFG_MAX_LAG:   m_max_lag    = val[10:0];
            CFG_FRAME_LEN: m_frame_len  = val[12:0];
            CFG_RATE:      m_rate       = val[17:0];
            CFG_ABS_THR:   m_abs_thr    = val[15:0];
            CFG_VOICED:    m_voiced_lim = val[15:0];
            default: ;
        endcase
    endtask

    // one beat on the sample channel; zero_result swaps in the typed all-zero result
    task automatic send_sample(logic signed [15:0] s, bit zero_result);
        t_pitch_result r;
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        sent_items++;
        if (take_sample(s, r)) begin
            if (zero_result) r = '{voiced: 1'b0, best_lag: '0, period_q8: '0,
                                   dip_value: '0, pitch_q4: '0};
            pending_results = {pending_results, r};
        end
    endtask

    // sender holds off until every result is back, then lets the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // burst/gap pacing ahead of each beat
    int burst_left;
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
        end
    endtask

    // ---------------------------------------------------------------- receiver
    int stall_mode, stall_left;
    always @(posedge i_clk) begin
        t_pitch_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_voiced !== e.voiced) begin
                    $error("voiced expected %0d got %0d", e.voiced, o_voiced);
                    fail_count++;
                end
                if (o_best_lag !== e.best_lag) begin
                    $error("best_lag expected %0d got %0d", e.best_lag, o_best_lag);
                    fail_count++;
                end
                if (o_period_q8 !== e.period_q8) begin
                    $error("period_q8 expected %0d got %0d", e.period_q8, o_period_q8);
                    fail_count++;
                end
                if (o_dip_value !== e.dip_value) begin
                    $error("dip_value expected %0d got %0d", e.dip_value, o_dip_value);
                    fail_count++;
                end
                if (o_pitch_q4 !== e.pitch_q4) begin
                    $error("pitch_q4 expected %0d got %0d", e.pitch_q4, o_pitch_q4);
                    fail_count++;
                end
            end
        end
        // stall pattern: free, coin toss, mostly stalled, alternating
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= $urandom_range(0, 1);
            2: i_out_stall <= ($urandom_range(0, 7) != 0);
            default: i_out_stall <= ~i_out_stall;
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    t_stim_row table_rows[$];

    function automatic void add_cfg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        t_stim_row row;
        row = '{is_cfg: 1, idx: idx, data: val, smp: '0, zero_result: 0};
        table_rows = {table_rows, row};
    endfunction

    function automatic void add_smp(logic signed [15:0] s, bit z);
        t_stim_row row;
        row = '{is_cfg: 0, idx: CFG_MIN_LAG, data: '0, smp: s, zero_result: z};
        table_rows = {table_rows, row};
    endfunction

    function automatic logic signed [15:0] sat16(int v);
        return (v > 32767) ? 16'sd32767 : (v < -32768) ? -16'sd32768 : 16'(v);
    endfunction

    initial begin
        int unsigned        lo, hi, flen, per, mode, amp, noise;
        int                 wave[MAX_LAG];
        logic signed [15:0] cval;
        bit                 last_cfg;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_MIN_LAG;
        i_cfg_data  = '0;
        fail_count  = 0;
        cycle_count = 0;
        sent_items  = 0;
        stall_mode  = 0;
        stall_left  = 0;
        burst_left  = 0;
        fill_count  = 0;
        m_min_lag    = RST_MIN_LAG;
        m_max_lag    = RST_MAX_LAG;
        m_frame_len  = RST_FRAME_LEN;
        m_rate       = RST_RATE;
        m_abs_thr    = RST_ABS_THR;
        m_voiced_lim = RST_VOICED;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // frame length 0 clamps to 1, window empty: each sample gives zeros
        add_cfg(CFG_FRAME_LEN, 0);
        add_smp(-16'sd32768, 1);
        add_smp(16'sd32767, 1);
        // flat frame: every difference zero, normalised value pinned at one
        add_cfg(CFG_MIN_LAG, 0);
        add_cfg(CFG_MAX_LAG, 4);
        add_cfg(CFG_FRAME_LEN, 10);
        add_cfg(CFG_RATE, 18'h3FFFF);
        add_cfg(CFG_ABS_THR, 16'hFFFF);
        add_cfg(CFG_VOICED, 16'hFFFF);
        for (int k = 0; k < 10; k++) add_smp(16'sd5, 0);
        // lags saturate to the top, max raised to min, window empty
        add_cfg(CFG_MIN_LAG, 11'h7FF);
        add_cfg(CFG_MAX_LAG, 0);
        add_cfg(CFG_FRAME_LEN, 13'h1FFF);
        add_cfg(CFG_FRAME_LEN, 3);
        add_smp(16'sd1, 0);
        add_smp(-16'sd1, 0);
        add_smp(16'sd0, 1);
        // full-scale square wave of period two, zero thresholds and rate
        add_cfg(CFG_MIN_LAG, 2);
        add_cfg(CFG_MAX_LAG, 4);
        add_cfg(CFG_FRAME_LEN, 8);
        add_cfg(CFG_RATE, 0);
        add_cfg(CFG_ABS_THR, 0);
        add_cfg(CFG_VOICED, 0);
        for (int k = 0; k < 8; k++) add_smp((k % 2) ? -16'sd32768 : 16'sd32767, 0);

        last_cfg = 0;
        foreach (table_rows[n]) begin
            if (table_rows[n].is_cfg) begin
                if (!last_cfg) drain();
                write_reg(table_rows[n].idx, table_rows[n].data);
                last_cfg = 1;
            end else begin
                if (last_cfg) i_cfg_we <= 1'b0;
                send_sample(table_rows[n].smp, table_rows[n].zero_result);
                last_cfg = 0;
            end
        end

        // random phases of a few frames each, mostly small lags, small windows
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            drain();
            repeat (frame_cycles()) @(posedge i_clk);
            write_reg(CFG_MIN_LAG, ($urandom_range(0, 15) == 0) ? 11'($urandom_range(0, 2047))
                                                                : 11'($urandom_range(0, 10)));
            lo = lag_lo();
            write_reg(CFG_MAX_LAG, 11'(lo + $urandom_range(0, 12)));
            hi = lag_hi();
            flen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, hi) : hi + $urandom_range(1, 24);
            if (flen > 64) flen = $urandom_range(0, 8);
            write_reg(CFG_FRAME_LEN, 13'(flen));
            write_reg(CFG_RATE, 18'($urandom()));
            write_reg(CFG_ABS_THR, ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                                               : 16'($urandom_range(0, 16000)));
            write_reg(CFG_VOICED, ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                                              : 16'($urandom_range(0, 30000)));
            i_cfg_we <= 1'b0;
            flen = frame_len_eff();
            repeat ($urandom_range(1, 4)) begin
                mode  = $urandom_range(0, 9);
                per   = $urandom_range(lo, hi);
                amp   = $urandom_range(0, 15);
                noise = $urandom_range(0, 3) * $urandom_range(0, 64);
                cval  = 16'($urandom());
                for (int k = 0; k < per; k++) wave[k] = $signed(16'($urandom())) >>> (amp % 8);
                for (int unsigned k = 0; k < flen; k++) begin
                    pace();
                    if (mode < 6)
                        send_sample(sat16(wave[k % per] + int'($urandom_range(0, 2 * noise))
                                          - int'(noise)), 0);
                    else if (mode < 8)
                        send_sample(16'($urandom()), 0);
                    else if (mode == 8)
                        send_sample(cval, 0);
                    else
                        send_sample($urandom_range(0, 1) ? 16'sd32767 : -16'sd32768, 0);
                end
            end
        end

        drain();
        repeat (frame_cycles()) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
